// ===== rtl/psq_pkg.sv =====
`timescale 1ns / 1ps
package psq_pkg;

  // field and register widths
  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 22;
  localparam int LIMIT_W = 15;
  localparam int SPEED_W = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // datapath widths
  localparam int ACC_W   = 16;  // clamped integrator, |acc| <= 32767
  localparam int WIDE_W  = 17;  // integrator before clamp, error difference
  localparam int PROD_PW = GAIN_W + 1 + ERR_W;
  localparam int PROD_W  = GAIN_W + 1 + WIDE_W;
  localparam int SUM_W   = 42;
  localparam int FRAC_SH = 20;
  localparam int V_W     = SUM_W - FRAC_SH;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_QUANT = 2'd1,
    MODE_CLAMP = 2'd2,
    MODE_RAW   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_GAIN_PROP   = 2'd0,
    REG_GAIN_INTEG  = 2'd1,
    REG_GAIN_DERIV  = 2'd2,
    REG_INTEG_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [LIMIT_W-1:0] integ_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] steer;
    logic [SPEED_W-1:0]      speed;
  } qres_t;

  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 22'd943718;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG  = 22'd105;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV  = 22'd10486;
  localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 15'd12800;

  localparam logic [SPEED_W-1:0] SPEED_STOP = 8'd0;
  localparam logic [SPEED_W-1:0] SPEED_120  = 8'd120;
  localparam logic [SPEED_W-1:0] SPEED_130  = 8'd130;
  localparam logic [SPEED_W-1:0] SPEED_140  = 8'd140;
  localparam logic [SPEED_W-1:0] SPEED_150  = 8'd150;
  localparam logic [SPEED_W-1:0] SPEED_160  = 8'd160;

  // q8.8 thresholds on the rounded pid sum
  localparam logic signed [V_W-1:0] V_DEAD  = 22'sd1280;    // 5
  localparam logic signed [V_W-1:0] V_EDGE1 = 22'sd3840;    // 15
  localparam logic signed [V_W-1:0] V_EDGE2 = 22'sd6400;    // 25
  localparam logic signed [V_W-1:0] V_EDGE3 = 22'sd8960;    // 35
  localparam logic signed [V_W-1:0] V_EDGE4 = 22'sd11520;   // 45
  localparam logic signed [V_W-1:0] V_EDGE5 = 22'sd14080;   // 55
  localparam logic signed [V_W-1:0] V_CLAMP = 22'sd15360;   // 60
  localparam logic signed [V_W-1:0] V_S16_MAX = 22'sd32767;
  localparam logic signed [V_W-1:0] V_S16_MIN = -22'sd32768;

  localparam logic signed [ERR_W-1:0] STEER_10 = 16'sd2560;
  localparam logic signed [ERR_W-1:0] STEER_20 = 16'sd5120;
  localparam logic signed [ERR_W-1:0] STEER_30 = 16'sd7680;
  localparam logic signed [ERR_W-1:0] STEER_40 = 16'sd10240;
  localparam logic signed [ERR_W-1:0] STEER_50 = 16'sd12800;
  localparam logic signed [ERR_W-1:0] STEER_60 = 16'sd15360;

  // snap to multiples of 10 with a +/-5 dead band and speed per bin
  function automatic qres_t quantize(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] mag;
    qres_t r;
    mag = v[V_W-1] ? -v : v;
    if (mag <= V_DEAD) begin
      r.steer = '0;
      r.speed = SPEED_160;
    end else begin
      if (mag <= V_EDGE1) begin
        r.steer = STEER_10;
        r.speed = SPEED_150;
      end else if (mag <= V_EDGE2) begin
        r.steer = STEER_20;
        r.speed = SPEED_150;
      end else if (mag <= V_EDGE3) begin
        r.steer = STEER_30;
        r.speed = SPEED_140;
      end else if (mag <= V_EDGE4) begin
        r.steer = STEER_40;
        r.speed = SPEED_140;
      end else if (mag <= V_EDGE5) begin
        r.steer = STEER_50;
        r.speed = SPEED_130;
      end else begin
        r.steer = STEER_60;
        r.speed = SPEED_120;
      end
      if (v[V_W-1]) begin
        r.steer = -r.steer;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/psq_in_if.sv =====
`timescale 1ns / 1ps
interface psq_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] error_in;
  logic [1:0]  mode;

  modport source (output valid, output error_in, output mode, input ready);
  modport sink   (input valid, input error_in, input mode, output ready);
endinterface

// ===== rtl/psq_out_if.sv =====
`timescale 1ns / 1ps
interface psq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] steer;
  logic [7:0]  speed_centi;

  modport source (output valid, output steer, output speed_centi, input ready);
  modport sink   (input valid, input steer, input speed_centi, output ready);
endinterface

// ===== rtl/psq_cfg_regs.sv =====
`timescale 1ns / 1ps
module psq_cfg_regs
  import psq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop   <= RST_GAIN_PROP;
      cfg_r.gain_integ  <= RST_GAIN_INTEG;
      cfg_r.gain_deriv  <= RST_GAIN_DERIV;
      cfg_r.integ_limit <= RST_INTEG_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_PROP:   cfg_r.gain_prop   <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg_r.gain_integ  <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg_r.gain_deriv  <= pwdata[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_r.integ_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_PROP:   prdata = DATA_W'(cfg_r.gain_prop);
      REG_GAIN_INTEG:  prdata = DATA_W'(cfg_r.gain_integ);
      REG_GAIN_DERIV:  prdata = DATA_W'(cfg_r.gain_deriv);
      REG_INTEG_LIMIT: prdata = DATA_W'(cfg_r.integ_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pid_steer_quantizer_unit.sv =====
`timescale 1ns / 1ps
// an input beat passes through the input register (s0) and the output register to its result beat on out_ch
// throughput: one beat per cycle while out_ch is ready; the integrator add and clamp loop is combinational
// the three gain products, their sum and the mode stage sit between the input
// and output registers
// reset (rst_n low, synchronous): integrator, previous error and speed level
// clear to zero, gains and limit load their defaults, both pipeline stages empty
module pid_steer_quantizer_unit
  import psq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  psq_in_if.sink            in_ch,
  psq_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // register file on the apb side
  psq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // pipeline control: input register (s0) feeding the output register
  // ---------------------------------------------------------------------------
  logic                    s0_valid_r;
  logic signed [ERR_W-1:0] s0_err_r;
  mode_t                   s0_mode_r;

  logic                    out_valid_r;
  logic signed [ERR_W-1:0] out_steer_r;
  logic [SPEED_W-1:0]      out_speed_r;

  logic out_adv;   // output register can take a new beat
  logic step_en;   // s0 beat moves into the output register this cycle
  logic in_take;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign step_en  = s0_valid_r && out_adv;
  assign in_ch.ready = !s0_valid_r || out_adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  // payload only loads on an accepted beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_err_r  <= signed'(in_ch.error_in);
      s0_mode_r <= mode_t'(in_ch.mode);
    end
  end

  // ---------------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ERR_W-1:0] prev_r;
  logic [SPEED_W-1:0]      speed_r, speed_nxt;

  // integrator updated first, then the pid sum uses the unclamped value
  logic signed [WIDE_W-1:0]  acc_sum;
  logic signed [WIDE_W-1:0]  diff;
  logic signed [WIDE_W-1:0]  lim_pos;
  logic signed [WIDE_W-1:0]  lim_neg;

  assign acc_sum = WIDE_W'(acc_r) + WIDE_W'(s0_err_r);
  assign diff    = WIDE_W'(s0_err_r) - WIDE_W'(prev_r);
  assign lim_pos = signed'({2'b00, cfg.integ_limit});
  assign lim_neg = -lim_pos;

  // clamp after the sum is formed; limit always fits the 16 bit integrator
  always_comb begin
    if (acc_sum < lim_neg) begin
      acc_nxt = lim_neg[ACC_W-1:0];
    end else if (acc_sum > lim_pos) begin
      acc_nxt = lim_pos[ACC_W-1:0];
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  // three independent products, q2.20 gains against q8.8 terms
  logic signed [PROD_PW-1:0] p_prop;
  logic signed [PROD_W-1:0]  p_integ;
  logic signed [PROD_W-1:0]  p_deriv;
  logic signed [SUM_W-1:0]   sum_rnd;
  logic signed [V_W-1:0]     v;

  assign p_prop  = signed'({1'b0, cfg.gain_prop})  * s0_err_r;
  assign p_integ = signed'({1'b0, cfg.gain_integ}) * acc_sum;
  assign p_deriv = signed'({1'b0, cfg.gain_deriv}) * diff;

  // round to nearest, ties toward plus infinity, back to q14.8
  assign sum_rnd = SUM_W'(p_prop) + SUM_W'(p_integ) + SUM_W'(p_deriv)
                 + signed'(SUM_W'(1) << (FRAC_SH - 1));
  assign v       = sum_rnd[SUM_W-1:FRAC_SH];

  // ---------------------------------------------------------------------------
  // mode stage
  // ---------------------------------------------------------------------------
  qres_t                   qres;
  logic signed [ERR_W-1:0] steer_nxt;

  assign qres = quantize(v);

  always_comb begin
    steer_nxt = '0;
    speed_nxt = speed_r;
    case (s0_mode_r)
      MODE_STOP: begin
        steer_nxt = '0;
        speed_nxt = SPEED_STOP;
      end
      MODE_QUANT: begin
        steer_nxt = qres.steer;
        speed_nxt = qres.speed;
      end
      MODE_CLAMP: begin
        if (v < -V_CLAMP) begin
          steer_nxt = -V_CLAMP[ERR_W-1:0];
        end else if (v > V_CLAMP) begin
          steer_nxt = V_CLAMP[ERR_W-1:0];
        end else begin
          steer_nxt = v[ERR_W-1:0];
        end
        speed_nxt = SPEED_120;
      end
      MODE_RAW: begin
        // saturate to the output range, speed level kept
        if (v < V_S16_MIN) begin
          steer_nxt = V_S16_MIN[ERR_W-1:0];
        end else if (v > V_S16_MAX) begin
          steer_nxt = V_S16_MAX[ERR_W-1:0];
        end else begin
          steer_nxt = v[ERR_W-1:0];
        end
      end
      default: begin
        steer_nxt = '0;
        speed_nxt = speed_r;
      end
    endcase
  end

  // state advances with the beat that leaves s0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      prev_r  <= '0;
      speed_r <= '0;
    end else if (step_en) begin
      acc_r   <= acc_nxt;
      prev_r  <= s0_err_r;
      speed_r <= speed_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_steer_r <= steer_nxt;
      out_speed_r <= speed_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.steer       = out_steer_r;
  assign out_ch.speed_centi = out_speed_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // integrator sits inside the limit that applied at its last update
  a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step_en) |->
      (WIDE_W'(acc_r) <= signed'({2'b00, $past(cfg.integ_limit)})) &&
      (WIDE_W'(acc_r) >= -signed'({2'b00, $past(cfg.integ_limit)})))
    else $error("integrator outside clamp");

  // a result only appears when s0 held a beat
  a_out_from_s0: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s0_valid_r))
    else $error("result without source beat");

  // speed only takes the defined levels
  a_speed_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_speed_r == SPEED_STOP) || (out_speed_r == SPEED_120) ||
      (out_speed_r == SPEED_130) || (out_speed_r == SPEED_140) ||
      (out_speed_r == SPEED_150) || (out_speed_r == SPEED_160))
    else $error("speed level out of set");

endmodule

// ===== tb/steer_checker.sv =====
`timescale 1ns / 1ps
module steer_checker
  import psq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  psq_in_if                 in_ch,
  psq_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  // q8.8 steering grid
  localparam longint STEP_Q       = 2560;
  localparam longint DEAD_Q       = 1280;
  localparam longint FIRST_EDGE_Q = 3840;
  localparam longint CLAMP_Q      = 15360;
  localparam longint S16_MAX      = 32767;
  localparam longint S16_MIN      = -32768;

  cfg_t                  regs;
  logic signed [23:0]    integ;
  logic signed [15:0]    last_err;
  logic [SPEED_W-1:0]    speed_lvl;
  qres_t                 cmd_queue[$];

  // steering snapped to a 10 grid, speed from the bin
  function automatic qres_t snap_steer(input longint v);
    qres_t  r;
    longint mag;
    int     bin;
    if (v >= -DEAD_Q && v <= DEAD_Q) begin
      r.steer = '0;
      r.speed = SPEED_160;
      return r;
    end
    mag = (v < 0) ? -v : v;
    bin = 0;
    while (bin < 5 && mag > FIRST_EDGE_Q + longint'(bin) * STEP_Q) bin++;
    r.steer = 16'(longint'(bin + 1) * STEP_Q);
    if (v < 0) begin
      r.steer = -r.steer;
    end
    case (bin)
      0, 1:    r.speed = SPEED_150;
      2, 3:    r.speed = SPEED_140;
      4:       r.speed = SPEED_130;
      default: r.speed = SPEED_120;
    endcase
    return r;
  endfunction

  // one control update: integrate, pid sum on the unclamped integral, then clamp
  function automatic qres_t advance_loop(input logic signed [15:0] e, input mode_t m);
    longint acc_next, diff, total, v, lim;
    qres_t  r;
    qres_t  q;
    acc_next = longint'(integ) + longint'(e);
    diff     = longint'(e) - longint'(last_err);
    total    = longint'(regs.gain_prop) * longint'(e)
             + longint'(regs.gain_integ) * acc_next
             + longint'(regs.gain_deriv) * diff;
    v        = (total + 64'sd524288) >>> 20;
    last_err = e;
    lim      = longint'(regs.integ_limit);
    if (acc_next < -lim) acc_next = -lim;
    if (acc_next > lim) acc_next = lim;
    integ = 24'(acc_next);
    case (m)
      MODE_STOP: begin
        r.steer   = '0;
        speed_lvl = SPEED_STOP;
      end
      MODE_QUANT: begin
        q         = snap_steer(v);
        r.steer   = q.steer;
        speed_lvl = q.speed;
      end
      MODE_CLAMP: begin
        if (v < -CLAMP_Q) v = -CLAMP_Q;
        if (v > CLAMP_Q) v = CLAMP_Q;
        r.steer   = 16'(v);
        speed_lvl = SPEED_120;
      end
      default: begin
        if (v < S16_MIN) v = S16_MIN;
        if (v > S16_MAX) v = S16_MAX;
        r.steer = 16'(v);
      end
    endcase
    r.speed = speed_lvl;
    return r;
  endfunction

  always @(posedge clk) begin
    qres_t       exp_cmd;
    logic [31:0] reg_val;
    if (!rst_n) begin
      regs.gain_prop   = RST_GAIN_PROP;
      regs.gain_integ  = RST_GAIN_INTEG;
      regs.gain_deriv  = RST_GAIN_DERIV;
      regs.integ_limit = RST_INTEG_LIMIT;
      integ            = '0;
      last_err         = '0;
      speed_lvl        = '0;
      cmd_queue.delete();
      fail_count       = 0;
    end else begin
      if (psel && penable && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_GAIN_PROP:  reg_val = 32'(regs.gain_prop);
          REG_GAIN_INTEG: reg_val = 32'(regs.gain_integ);
          REG_GAIN_DERIV: reg_val = 32'(regs.gain_deriv);
          default:        reg_val = 32'(regs.integ_limit);
        endcase
        if (pwrite) begin
          case (reg_idx_t'(paddr[3:2]))
            REG_GAIN_PROP:  regs.gain_prop   = pwdata[GAIN_W-1:0];
            REG_GAIN_INTEG: regs.gain_integ  = pwdata[GAIN_W-1:0];
            REG_GAIN_DERIV: regs.gain_deriv  = pwdata[GAIN_W-1:0];
            default:        regs.integ_limit = pwdata[LIMIT_W-1:0];
          endcase
        end else if ((paddr[3:2] == REG_INTEG_LIMIT &&
                      prdata[LIMIT_W-1:0] !== reg_val[LIMIT_W-1:0]) ||
                     (paddr[3:2] != REG_INTEG_LIMIT &&
                      prdata[GAIN_W-1:0] !== reg_val[GAIN_W-1:0])) begin
          $display("%0t: register read at %0d, expected %0d, got %0d",
                   $time, paddr, reg_val, prdata);
          fail_count++;
        end
      end
      // retire first: a result can never belong to the beat taken in the same cycle
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got steer %0d speed %0d",
                   $time, $signed(out_ch.steer), out_ch.speed_centi);
          fail_count++;
        end else begin
          exp_cmd = cmd_queue.pop_front();
          if (out_ch.steer !== exp_cmd.steer) begin
            $display("%0t: steer mismatch, expected %0d, got %0d",
                     $time, exp_cmd.steer, $signed(out_ch.steer));
            fail_count++;
          end
          if (out_ch.speed_centi !== exp_cmd.speed) begin
            $display("%0t: speed mismatch, expected %0d, got %0d",
                     $time, exp_cmd.speed, out_ch.speed_centi);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_queue.push_back(advance_loop(in_ch.error_in, mode_t'(in_ch.mode)));
      end
    end
    pending = cmd_queue.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import psq_pkg::*;

  // generous bound: every beat waiting out the longest sender gap and receiver
  // stall, plus phase drains and register traffic, taken several times over
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_COUNT   = 22;
  localparam logic [31:0] GAIN_ONE = 32'd1 << 20;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                cycle_count;
  logic              quiet;      // no gaps or stalls while set
  int                dir_err [0:DIR_COUNT-1];
  mode_t             dir_mode [0:DIR_COUNT-1];

  psq_in_if  in_ch ();
  psq_out_if out_ch ();

  pid_steer_quantizer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  steer_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog on a plain cycle count
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure, changes only at the falling edge
  initial begin
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // error samples: mostly the steering range, some near bin edges, some extremes,
  // the rest anywhere in 16 bits
  function automatic logic [15:0] pick_error();
    int r;
    int e;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      e = int'($urandom_range(0, 36000)) - 18000;
    end else if (r < 70) begin
      e = 1280 + 2560 * int'($urandom_range(0, 5)) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) e = -e;
    end else if (r < 80) begin
      case ($urandom_range(0, 4))
        0:       e = 32767;
        1:       e = -32768;
        2:       e = 0;
        3:       e = -1;
        default: e = 1;
      endcase
    end else begin
      e = int'($urandom_range(0, 65535));
    end
    return 16'(e);
  endfunction

  // one beat on the input channel; returns right after the accepting edge
  task automatic push_sample(input logic [15:0] e, input mode_t m);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.error_in <= e;
    in_ch.mode     <= m;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender holds off until every expected result is back, then lets the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // setup then access cycle; pready is tied high but still honored
  task automatic apb_cycle(input logic wr, input reg_idx_t r, input logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write all four registers, then read them back for the checker
  task automatic load_gains(input logic [31:0] gp, input logic [31:0] gi,
                            input logic [31:0] gd, input logic [31:0] lim);
    apb_cycle(1'b1, REG_GAIN_PROP, gp);
    apb_cycle(1'b1, REG_GAIN_INTEG, gi);
    apb_cycle(1'b1, REG_GAIN_DERIV, gd);
    apb_cycle(1'b1, REG_INTEG_LIMIT, lim);
    apb_cycle(1'b0, REG_GAIN_PROP, '0);
    apb_cycle(1'b0, REG_GAIN_INTEG, '0);
    apb_cycle(1'b0, REG_GAIN_DERIV, '0);
    apb_cycle(1'b0, REG_INTEG_LIMIT, '0);
  endtask

  initial begin
    int ph;
    int k;
    int n_items;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.error_in = '0;
    in_ch.mode     = MODE_STOP;
    quiet          = 1'b0;

    // with unit proportional gain and no integral or derivative term the pid
    // sum equals the error, so these sit on or just past the bin edges and at the extremes
    dir_err  = '{1280, 1281, -1280, -1281, 3840, 3841, -3840, -3841, 6401, -8961,
                 11520, 14080, 14081, -14081,
                 15361, -15361, 15360,
                 32767, -32768,
                 -32768, 32767, -1};
    dir_mode = '{MODE_QUANT, MODE_QUANT, MODE_QUANT, MODE_QUANT, MODE_QUANT,
                 MODE_QUANT, MODE_QUANT, MODE_QUANT, MODE_QUANT, MODE_QUANT,
                 MODE_QUANT, MODE_QUANT, MODE_QUANT, MODE_QUANT,
                 MODE_CLAMP, MODE_CLAMP, MODE_CLAMP,
                 MODE_STOP, MODE_STOP,
                 MODE_RAW, MODE_RAW, MODE_RAW};

    // reset released at a falling edge, away from the sampling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          // pass-through gains for exact edge checks
          load_gains(GAIN_ONE, '0, '0, 32'(RST_INTEG_LIMIT));
          n_items = 100;
        end
        1: begin
          // back to the power-up values
          load_gains(32'(RST_GAIN_PROP), 32'(RST_GAIN_INTEG), 32'(RST_GAIN_DERIV),
                     32'(RST_INTEG_LIMIT));
          n_items = 150;
        end
        2: begin
          // everything at the top, upper write bits set and dropped
          load_gains('1, '1, '1, '1);
          n_items = 100;
        end
        3: begin
          // all zero, integrator pinned at zero
          load_gains('0, '0, '0, '0);
          n_items = 80;
        end
        4: begin
          // strong integral with a small clamp, clamp after the sum matters here
          load_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE, $urandom_range(1, 600));
          n_items = 120;
        end
        default: begin
          load_gains($urandom(), $urandom(), $urandom(), $urandom());
          n_items = 130;
        end
      endcase

      if (ph == 0) begin
        for (k = 0; k < DIR_COUNT; k++) begin
          push_sample(16'(dir_err[k]), dir_mode[k]);
        end
      end

      for (k = 0; k < n_items; k++) begin
        // stretches with neither gaps nor stalls
        if (k % 64 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 99) == 0) begin
          drain_results();
        end
        push_sample(pick_error(), mode_t'($urandom_range(0, 3)));
      end
      drain_results();
    end

    // catch any stray beat after the last expected one
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
